// ===== design/sfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared constants and the byte-wide crc update for the sensor frame decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned PosW  = 3;

  // crc-16, reflected form
  localparam logic [WordW-1:0] CRC_START = 16'hFFFF;
  localparam logic [WordW-1:0] CRC_POLY  = 16'hA001;

  // byte positions within a response frame
  localparam logic [PosW-1:0] POS_FIRST  = 3'd0;
  localparam logic [PosW-1:0] POS_HUM_HI = 3'd2;
  localparam logic [PosW-1:0] POS_HUM_LO = 3'd3;
  localparam logic [PosW-1:0] POS_TMP_HI = 3'd4;
  localparam logic [PosW-1:0] POS_TMP_LO = 3'd5;
  localparam logic [PosW-1:0] POS_CRC_LO = 3'd6;
  localparam logic [PosW-1:0] POS_CRC_HI = 3'd7;

  // humidity / 10 as multiply by ceil(2^19 / 10), exact for any 16-bit value
  localparam logic [WordW-1:0] HUM_RECIP = 16'd52429;
  localparam int unsigned      HUM_SHIFT = 19;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  // one byte through the reflected crc, one bit per step
  function automatic logic [WordW-1:0] crc16_feed(input logic [WordW-1:0] crc,
                                                  input logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc ^ {{(WordW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/sfcd_decode.sv =====
// ----------------------------------------------------------------------------
// sfcd_decode
// Converts the captured raw words into temperature and humidity readings.
// ----------------------------------------------------------------------------
module sfcd_decode (
  input  logic [sfcd_pkg::WordW-1:0]        temp_raw,
  input  logic [sfcd_pkg::WordW-1:0]        hum_raw,
  output logic signed [sfcd_pkg::WordW-1:0] temperature,
  output logic [sfcd_pkg::ByteW-1:0]        humidity
);
  import sfcd_pkg::*;

  logic [WordW-1:0]   temp_mag;
  logic [2*WordW-1:0] hum_prod;

  // sign-magnitude to two's complement, negative zero gives zero
  assign temp_mag    = {1'b0, temp_raw[WordW-2:0]};
  assign temperature = temp_raw[WordW-1] ? $signed(-temp_mag) : $signed(temp_mag);

  // divide by ten through the reciprocal, keep the low byte of the quotient
  assign hum_prod = hum_raw * HUM_RECIP;
  assign humidity = hum_prod[HUM_SHIFT +: ByteW];

endmodule

// ===== design/sensor_frame_crc_decoder_core.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_core
// Crc-checked decoder for the 8-byte response frame of a climate sensor.
// ----------------------------------------------------------------------------
// Takes one response byte per beat on the in_ channel, in_tuser high on the
// first byte of a frame; bytes keep counting 0..7 and wrap when no start flag
// comes. Bytes 0..5 run through the crc, byte 6 and byte 7 carry the received
// crc low byte first. On byte 7 one result beat leaves on out_: out_tuser is
// the status (0 crc good and readings updated, 1 crc mismatch) and out_tdata
// carries the last good temperature and humidity. A byte goes through one input
// register and one result stage: byte 7 waits in the input register until the
// result register is free and then loads it. The rate is one byte per cycle,
// set by the combinational byte-wide crc update; only byte 7 waits, when a
// previous result has not yet been taken.
module sensor_frame_crc_decoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sfcd_pkg::ByteW-1:0]  in_tdata,   // [7:0] byte_value
  input  logic                        in_tuser,   // [0] frame_start
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // [15:0] temperature, [23:16] humidity
  output logic                        out_tuser   // [0] status
);
  import sfcd_pkg::*;

  // input stage
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_start_r;

  // frame state
  logic [PosW-1:0]  pos_r;
  logic [WordW-1:0] crc_r;
  logic [WordW-1:0] hum_raw_r;
  logic [WordW-1:0] temp_raw_r;
  logic [ByteW-1:0] crc_lo_r;
  logic [WordW-1:0] last_temp_r;
  logic [ByteW-1:0] last_hum_r;

  // result stage
  logic             out_valid_r;
  logic             status_r;

  logic              [PosW-1:0]  pos_eff;
  logic                          s1_last;
  logic                          out_free;
  logic                          s1_adv;
  logic                          out_load;
  logic                          crc_ok;
  logic              [WordW-1:0] crc_base;
  logic              [WordW-1:0] crc_nxt;
  logic signed       [WordW-1:0] dec_temp;
  logic              [ByteW-1:0] dec_hum;

  // position of the byte held in the input stage
  assign pos_eff  = s1_start_r ? POS_FIRST : pos_r;
  assign s1_last  = (pos_eff == POS_CRC_HI);

  // handshake: only the final byte of a frame needs room in the result stage
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last || out_free);
  assign out_load  = s1_valid_r && s1_last && out_free;
  assign in_tready = !s1_valid_r || s1_adv;

  // crc over bytes 0..5, restarted on byte 0
  assign crc_base = (pos_eff == POS_FIRST) ? CRC_START : crc_r;
  assign crc_nxt  = crc16_feed(crc_base, s1_byte_r);
  assign crc_ok   = ({s1_byte_r, crc_lo_r} == crc_r);

  sfcd_decode u_decode (
    .temp_raw    (temp_raw_r),
    .hum_raw     (hum_raw_r),
    .temperature (dec_temp),
    .humidity    (dec_hum)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // frame state update as a byte leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_FIRST;
      crc_r       <= CRC_START;
      hum_raw_r   <= '0;
      temp_raw_r  <= '0;
      crc_lo_r    <= '0;
      last_temp_r <= '0;
      last_hum_r  <= '0;
    end else if (s1_adv) begin
      pos_r <= pos_eff + 3'd1;
      if (pos_eff < POS_CRC_LO) begin
        crc_r <= crc_nxt;
      end
      case (pos_eff)
        POS_HUM_HI: hum_raw_r[WordW-1:ByteW]  <= s1_byte_r;
        POS_HUM_LO: hum_raw_r[ByteW-1:0]      <= s1_byte_r;
        POS_TMP_HI: temp_raw_r[WordW-1:ByteW] <= s1_byte_r;
        POS_TMP_LO: temp_raw_r[ByteW-1:0]     <= s1_byte_r;
        POS_CRC_LO: crc_lo_r                  <= s1_byte_r;
        POS_CRC_HI: begin
          if (crc_ok) begin
            last_temp_r <= dec_temp;
            last_hum_r  <= dec_hum;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= crc_ok ? STATUS_OK : STATUS_CRC_ERR;
    end
  end

  // readings change only on a result load, so they drive the beat directly
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {last_hum_r, last_temp_r};

`ifndef SYNTHESIS
  // a result is loaded only for the last byte of a frame
  a_load_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (pos_eff == POS_CRC_HI))
    else $error("result loaded for a byte other than the last");

  // input stalls only behind a final byte waiting on a full result stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last && out_valid_r && !out_tready))
    else $error("input stalled without a pending result");

  // a crc mismatch leaves the last good readings alone
  a_keep_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !crc_ok) |=> ($stable(last_temp_r) && $stable(last_hum_r)
                               && out_tuser == STATUS_CRC_ERR))
    else $error("readings changed on a crc mismatch");

  // position counts up by one when no frame start is flagged
  a_pos_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_start_r) |=> (pos_r == $past(pos_r) + 3'd1))
    else $error("byte position skipped");
`endif

endmodule

// ===== verif/sensor_frame_crc_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_core_test
// Self-checking bench for the crc-checked sensor frame decoder.
// ----------------------------------------------------------------------------
// Byte beats go in on the in_ stream and are mirrored by a frame tracker in
// the bench, which keeps its own crc, captured bytes and last good readings
// and queues one expected reading for every byte 7 it sees. Each out_ beat is
// checked field by field against the oldest queued reading. A few directed
// frames cover reset values, negative zero, large humidity, wraparound and a
// dropped partial frame. Random traffic that is mostly well-formed frames
// follows, under three idle and stall mixes.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder_core_test;
  import sfcd_pkg::*;

  localparam int StallLimit = 500;

  typedef logic [7:0][7:0] frame_t;  // element i is frame byte i

  typedef struct packed {
    logic        status;
    logic [15:0] temperature;
    logic [7:0]  humidity;
  } reading_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] byte_value
  logic        in_tuser;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [15:0] temperature, [23:16] humidity
  logic        out_tuser;  // [0] status

  // frame tracker state
  logic [2:0]  frame_pos   = POS_FIRST;
  logic [15:0] crc_acc     = CRC_START;
  logic [15:0] hum_raw     = '0;
  logic [15:0] temp_raw    = '0;
  logic [7:0]  rx_crc_lo   = '0;
  logic [15:0] last_temp   = '0;
  logic [7:0]  last_hum    = '0;

  reading_t expected_readings[$];
  reading_t want;
  int       mismatches = 0;
  int       stalled_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  sensor_frame_crc_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // reflected crc-16, one input bit per step
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  // well-formed frame with the crc appended low byte first
  function automatic frame_t build_frame(input logic [7:0] addr, input logic [7:0] count,
                                         input logic [15:0] hum, input logic [15:0] temp);
    frame_t      f;
    logic [15:0] c;
    f[0] = addr;
    f[1] = count;
    f[2] = hum[15:8];
    f[3] = hum[7:0];
    f[4] = temp[15:8];
    f[5] = temp[7:0];
    c = CRC_START;
    for (int i = 0; i < 6; i++) c = crc_step(c, f[i]);
    f[6] = c[7:0];
    f[7] = c[15:8];
    return f;
  endfunction

  // random reading word, now and then a corner value
  function automatic logic [15:0] pick_word();
    case ($urandom_range(11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'd2559;
      5: return 16'd2560;
      default: return 16'($urandom);
    endcase
  endfunction

  // frame tracker: follows one accepted byte, queues a reading on byte 7
  task automatic track_byte(input logic [7:0] b, input logic start);
    logic [2:0]  pos;
    logic [14:0] mag;
    reading_t    r;
    pos = start ? POS_FIRST : frame_pos;
    case (pos)
      POS_CRC_LO: rx_crc_lo = b;
      POS_CRC_HI: begin
        if ({b, rx_crc_lo} == crc_acc) begin
          mag = temp_raw[14:0];
          last_temp = temp_raw[15] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
          last_hum = 8'(hum_raw / 16'd10);
          r.status = STATUS_OK;
        end else begin
          r.status = STATUS_CRC_ERR;
        end
        r.temperature = last_temp;
        r.humidity = last_hum;
        expected_readings.push_back(r);
      end
      default: begin
        crc_acc = crc_step((pos == POS_FIRST) ? CRC_START : crc_acc, b);
        if (pos == POS_HUM_HI) hum_raw[15:8] = b;
        if (pos == POS_HUM_LO) hum_raw[7:0] = b;
        if (pos == POS_TMP_HI) temp_raw[15:8] = b;
        if (pos == POS_TMP_LO) temp_raw[7:0] = b;
      end
    endcase
    frame_pos = pos + 3'd1;
  endtask

  // one byte beat; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tuser = start;
    do @(posedge clk); while (!in_tready);
    track_byte(b, start);
    @(negedge clk);
  endtask

  // first nbytes of a frame, start flag only on byte 0
  task automatic send_frame(input frame_t f, input logic lead_start, input int nbytes);
    for (int i = 0; i < nbytes; i++) send_byte(f[i], (i == 0) ? lead_start : 1'b0);
  endtask

  // hold the input until every queued reading has come out
  task automatic hold_until_drained();
    in_tvalid = 1'b0;
    wait (expected_readings.size() == 0);
    @(negedge clk);
  endtask

  // bad crc right after reset reports the reset readings
  task automatic test_mismatch_after_reset();
    frame_t f;
    f = build_frame(8'hFF, 8'h04, 16'hFFFF, 16'h7FFF);
    f[6] = f[6] ^ 8'hFF;
    send_frame(f, 1'b1, 8);
  endtask

  // negative zero and large humidity, then a wrapped frame with no start flag
  task automatic test_sign_magnitude_corners();
    send_frame(build_frame(8'h03, 8'h04, 16'hFFFF, 16'h8000), 1'b1, 8);
    send_frame(build_frame(8'h00, 8'h00, 16'd2560, 16'hFFFF), 1'b0, 8);
  endtask

  // a partial frame is dropped when a new start flag comes
  task automatic test_frame_restart();
    send_frame(build_frame(8'h03, 8'h04, 16'h1234, 16'h8123), 1'b1, 3);
    send_frame(build_frame(8'h03, 8'h04, 16'd2559, 16'h7FFF), 1'b1, 8);
  endtask

  // mostly good frames, some corrupted, truncated or loose noise bytes
  task automatic test_random_traffic(input int n_bytes, input int idle_pct,
                                     input int stall_pct);
    int     sent;
    int     kind;
    int     cut;
    int     idx;
    frame_t f;
    logic   lead;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(99);
      f = build_frame(8'($urandom), 8'($urandom), pick_word(), pick_word());
      lead = (frame_pos != POS_FIRST) ? 1'b1 : 1'($urandom_range(1));
      if (kind < 80) begin
        send_frame(f, lead, 8);
        sent += 8;
      end else if (kind < 88) begin
        idx = $urandom_range(7);
        f[idx] = f[idx] ^ 8'($urandom_range(255, 1));
        send_frame(f, lead, 8);
        sent += 8;
      end else if (kind < 95) begin
        cut = $urandom_range(7, 1);
        send_frame(f, lead, cut);
        sent += cut;
      end else begin
        cut = $urandom_range(4, 1);
        repeat (cut) send_byte(8'($urandom), 1'($urandom_range(1)));
        sent += cut;
      end
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0b temp %0d hum %0d",
                 $time, out_tuser, $signed(out_tdata[15:0]), out_tdata[23:16]);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status mismatch, expected %0b, actual %0b",
                   $time, want.status, out_tuser);
          mismatches++;
        end
        if (out_tdata[15:0] !== want.temperature) begin
          $display("%0t: temperature mismatch, expected %0d, actual %0d",
                   $time, $signed(want.temperature), $signed(out_tdata[15:0]));
          mismatches++;
        end
        if (out_tdata[23:16] !== want.humidity) begin
          $display("%0t: humidity mismatch, expected %0d, actual %0d",
                   $time, want.humidity, out_tdata[23:16]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= StallLimit) begin
        $display("sensor_frame_crc_decoder_core verification failed");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    send_idle_pct = 20;
    recv_stall_pct = 45;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_mismatch_after_reset();
    test_sign_magnitude_corners();
    test_frame_restart();
    test_random_traffic(600, 20, 45);
    hold_until_drained();
    test_random_traffic(600, 45, 20);
    hold_until_drained();
    test_random_traffic(610, 0, 0);

    // drain and let any stray beat show up
    in_tvalid = 1'b0;
    wait (expected_readings.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("sensor_frame_crc_decoder_core verification clean");
    end else begin
      $display("sensor_frame_crc_decoder_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sfcd_pkg.sv
design/sfcd_decode.sv
design/sensor_frame_crc_decoder_core.sv
verif/sensor_frame_crc_decoder_core_test.sv
